// ===== rtl/rwdf_pkg.sv =====
// shared types and codes for the receive window duplicate filter
`timescale 1ns / 1ps

package rwdf_pkg;

	// frame kind codes
	localparam logic [2:0] KIND_INTEREST = 3'd0;
	localparam logic [2:0] KIND_DATA     = 3'd1;
	localparam logic [2:0] KIND_DACK     = 3'd2;
	localparam logic [2:0] KIND_ANNOUNCE = 3'd4;
	localparam logic [2:0] KIND_INJECT   = 3'd5;

	// drop cause codes
	localparam logic [2:0] CAUSE_NONE      = 3'd0;
	localparam logic [2:0] CAUSE_UNK_FLOW  = 3'd1;
	localparam logic [2:0] CAUSE_DUPLICATE = 3'd2;
	localparam logic [2:0] CAUSE_DACK      = 3'd3;
	localparam logic [2:0] CAUSE_UNK_KIND  = 3'd4;

	// serial divider step count, one quotient bit per cycle
	localparam int         DIV_CNT_W = 5;
	localparam logic [4:0] DIV_LAST  = 5'd31;

	// reciprocal shift used to reduce a sequence number modulo the window
	localparam int MOD_SHIFT = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EVAL,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/rwdf_intf.sv =====
// valid/ready channel interfaces for frame headers and filter results
`timescale 1ns / 1ps

interface rwdf_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_kind;
	logic [3:0]  flow_index;
	logic        flow_known;
	logic [15:0] frame_seq;
	logic [31:0] arrival_tick;

	modport source (
		output valid, frame_kind, flow_index, flow_known, frame_seq, arrival_tick,
		input  ready
	);
	modport sink (
		input  valid, frame_kind, flow_index, flow_known, frame_seq, arrival_tick,
		output ready
	);
endinterface

interface rwdf_out_if;
	logic        valid;
	logic        ready;
	logic        deliver;
	logic [2:0]  drop_cause;
	logic [15:0] seq_out;
	logic [2:0]  kind_out;
	logic        spacing_updated;
	logic [31:0] spacing_value;

	modport source (
		output valid, deliver, drop_cause, seq_out, kind_out, spacing_updated,
		       spacing_value,
		input  ready
	);
	modport sink (
		input  valid, deliver, drop_cause, seq_out, kind_out, spacing_updated,
		       spacing_value,
		output ready
	);
endinterface

// ===== rtl/rwdf_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps

module rwdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/rwdf_divider.sv =====
// restoring serial divider, 32-bit dividend by 16-bit divisor
`timescale 1ns / 1ps

module rwdf_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  rwdf_pkg::div_req_t req,
	output rwdf_pkg::div_rsp_t rsp
);
	import rwdf_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [15:0]          rem_q;
	logic [31:0]          quo_q;
	logic [15:0]          dvs_q;
	logic [16:0]          trial;
	logic [16:0]          diff;
	logic                 ge;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, quo_q[31]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_LAST;
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/rx_window_duplicate_filter.sv =====
// receive window duplicate filter: a frame header is taken only in the idle state, then lookup and evaluation
// a data frame that computes its flow's tick spacing also waits in the divide state for the serial divider
// per-flow state sits in one ram entry; one read, then a write-back for a known, non-duplicate data frame
// the result register lets a new frame in while the last word waits to be taken
// reset clears control and the per-flow valid flags; an unwritten flow reads as all zero
`timescale 1ns / 1ps

module rx_window_duplicate_filter #(
	parameter int WINDOW_BITS = 64,
	parameter int FLOW_SLOTS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rwdf_in_if.sink    rx,
	rwdf_out_if.source res
);
	import rwdf_pkg::*;

	localparam int AW     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
	localparam int PW     = $clog2(WINDOW_BITS);
	localparam int OFF_LAT = WINDOW_BITS;
	localparam int OFF_POS = OFF_LAT + 16;
	localparam int OFF_FT  = OFF_POS + PW;
	localparam int OFF_ST  = OFF_FT + 32;
	localparam int OFF_LS  = OFF_ST + 32;
	localparam int OFF_SP  = OFF_LS + 32 - 16;
	localparam int ENT_W   = OFF_SP + 32;
	localparam logic [23:0] MOD_RECIP =
		24'(((64'd1 << MOD_SHIFT) + 64'(WINDOW_BITS) - 64'd1) / 64'(WINDOW_BITS));
	localparam logic [15:0] WIN16 = 16'(WINDOW_BITS);

	state_t state_q, state_d;

	logic                 accept;
	logic [39:0]          quot_prod;
	logic [7:0]           idx_ext;
	logic                 in_range;
	logic [2:0]           kind_q;
	logic                 known_q;
	logic [15:0]          seq_q;
	logic [31:0]          tick_q;
	logic [AW-1:0]        addr_q;
	logic [15:0]          quot_q;
	logic [31:0]          quot_mul;
	logic [15:0]          seq_rem;
	logic [PW-1:0]        pos_q;
	logic [ENT_W-1:0]     ent_q;
	logic [ENT_W-1:0]     ram_rdata;
	logic [ENT_W-1:0]     ram_wdata;
	logic                 ram_we;
	logic [FLOW_SLOTS-1:0] valid_q;

	logic [WINDOW_BITS-1:0] bits_old, bits_new, clr_mask;
	logic [15:0]          lat_old, lat_new, gap, ls_old, ls_new;
	logic [PW-1:0]        lpos_old, lpos_new;
	logic [31:0]          ft_old, ft_new, st_old, st_new, sp_old, sp_new;
	logic [PW:0]          i_w, off;
	logic [16:0]          dseq;
	logic                 data_path, ahead, dup, mark, upd, div_need, wr_need;
	logic                 ev_deliver;
	logic [2:0]           ev_cause;
	logic [15:0]          ev_seq;
	logic [31:0]          ev_spacing;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic out_free, finish;
	logic        out_valid_q;
	logic        deliver_q;
	logic [2:0]  cause_q;
	logic [15:0] seq_out_q;
	logic [2:0]  kind_out_q;
	logic        upd_q;
	logic [31:0] spacing_q;

	// flow state memory
	rwdf_ram #(
		.WIDTH (ENT_W),
		.DEPTH (FLOW_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.raddr (idx_ext[AW-1:0]),
		.rdata (ram_rdata)
	);

	// spacing divider
	rwdf_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// input decode and sequence modulo reduction by reciprocal
	always_comb begin
		accept    = rx.valid && rx.ready;
		idx_ext   = {4'b0000, rx.flow_index};
		in_range  = ({1'b0, idx_ext} < 9'(FLOW_SLOTS));
		quot_prod = {24'd0, rx.frame_seq} * {16'd0, MOD_RECIP};
		quot_mul  = 32'(quot_q) * 32'(WIN16);
		seq_rem   = seq_q - quot_mul[15:0];
	end

	// frame registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= rx.frame_kind;
			known_q <= rx.flow_known && in_range;
			seq_q   <= rx.frame_seq;
			tick_q  <= rx.arrival_tick;
			addr_q  <= idx_ext[AW-1:0];
			quot_q  <= quot_prod[39:24];
		end
		if (state_q == ST_LOOK) begin
			ent_q <= valid_q[addr_q] ? ram_rdata : '0;
			pos_q <= seq_rem[PW-1:0];
		end
	end

	// entry fields
	always_comb begin
		bits_old = ent_q[WINDOW_BITS-1:0];
		lat_old  = ent_q[OFF_LAT +: 16];
		lpos_old = ent_q[OFF_POS +: PW];
		ft_old   = ent_q[OFF_FT +: 32];
		st_old   = ent_q[OFF_ST +: 32];
		ls_old   = ent_q[OFF_LS +: 16];
		sp_old   = ent_q[OFF_SP +: 32];
	end

	// window update: clear the gap, detect duplicates, mark the frame
	always_comb begin
		i_w      = '0;
		off      = '0;
		ahead    = (lat_old < seq_q);
		gap      = seq_q - lat_old;
		clr_mask = '0;
		for (int i = 0; i < WINDOW_BITS; i++) begin
			i_w = (PW+1)'(i);
			if (i_w > {1'b0, lpos_old}) begin
				off = i_w - {1'b0, lpos_old};
			end else begin
				off = i_w + (PW+1)'(WINDOW_BITS) - {1'b0, lpos_old};
			end
			clr_mask[i] = (16'(off) <= gap);
		end
		dup  = !ahead && bits_old[pos_q];
		mark = ahead || ((lat_old - seq_q) < WIN16);
		if (!ahead) begin
			bits_new = bits_old;
		end else if (gap >= WIN16) begin
			bits_new = '0;
		end else begin
			bits_new = bits_old & ~clr_mask;
		end
		if (mark) begin
			bits_new[pos_q] = 1'b1;
		end
		lat_new  = ahead ? seq_q : lat_old;
		lpos_new = ahead ? pos_q : lpos_old;
	end

	// tick spacing estimate and divider request
	always_comb begin
		dseq     = {1'b0, seq_q} - {1'b0, ls_old};
		ft_new   = ft_old;
		st_new   = st_old;
		upd      = 1'b0;
		if (ft_old == '0) begin
			ft_new = tick_q;
		end else if (st_old == '0) begin
			st_new = tick_q;
			ft_new = '0;
			upd    = !dseq[16] && (dseq != '0);
		end
		ls_new   = seq_q;
		sp_new   = upd ? div_rsp.quotient : sp_old;
		data_path = (kind_q == KIND_DATA) && known_q;
		div_need  = data_path && !dup && upd;
		wr_need   = data_path && !dup;
		ram_wdata = {sp_new, ls_new, st_new, ft_new, lpos_new, lat_new, bits_new};
		div_req.start    = (state_q == ST_EVAL) && div_need;
		div_req.dividend = tick_q - ft_old;
		div_req.divisor  = dseq[15:0];
	end

	// result classification
	always_comb begin
		ev_deliver = 1'b0;
		ev_cause   = CAUSE_NONE;
		ev_seq     = '0;
		ev_spacing = '0;
		unique case (kind_q)
			KIND_INTEREST, KIND_ANNOUNCE: begin
				ev_deliver = 1'b1;
			end
			KIND_INJECT: begin
				ev_deliver = 1'b1;
				ev_seq     = seq_q;
			end
			KIND_DACK: begin
				ev_cause = CAUSE_DACK;
			end
			KIND_DATA: begin
				if (!known_q) begin
					ev_cause = CAUSE_UNK_FLOW;
				end else if (dup) begin
					ev_cause   = CAUSE_DUPLICATE;
					ev_spacing = sp_old;
				end else begin
					ev_deliver = 1'b1;
					ev_seq     = seq_q;
					ev_spacing = sp_new;
				end
			end
			default: begin
				ev_cause = CAUSE_UNK_KIND;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_LOOK;
			ST_LOOK: state_d = ST_EVAL;
			ST_EVAL: begin
				if (div_need) begin
					state_d = ST_DIV;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: if (div_rsp.done && out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		out_free      = !out_valid_q || res.ready;
		rx.ready      = (state_q == ST_IDLE);
		finish        = ((state_q == ST_EVAL) && !div_need && out_free) ||
		                ((state_q == ST_DIV) && div_rsp.done && out_free);
		ram_we        = finish && wr_need;
	end

	// state and flow valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (finish) begin
			deliver_q  <= ev_deliver;
			cause_q    <= ev_cause;
			seq_out_q  <= ev_seq;
			kind_out_q <= kind_q;
			upd_q      <= div_need;
			spacing_q  <= ev_spacing;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.deliver         = deliver_q;
	assign res.drop_cause      = cause_q;
	assign res.seq_out         = seq_out_q;
	assign res.kind_out        = kind_out_q;
	assign res.spacing_updated = upd_q;
	assign res.spacing_value   = spacing_q;

`ifndef SYNTHESIS
	// flow memory is written only when a frame finishes
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_EVAL || state_q == ST_DIV))
		else $error("flow write outside evaluation");

	// an accepted word always goes to the lookup step
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOOK))
		else $error("accepted word not looked up");

	// divider is started only from evaluation
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == ST_EVAL))
		else $error("divider started outside evaluation");

	// a delivered word carries no drop cause, a dropped one does
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.deliver == (res.drop_cause == CAUSE_NONE)))
		else $error("deliver and drop cause disagree");

	// the spacing estimate is computed only by a delivered data word
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.spacing_updated) |-> (res.deliver && res.kind_out == KIND_DATA))
		else $error("spacing update on a word that was not delivered data");
`endif

endmodule

// ===== tb/sv/rwdf_verdict_monitor.sv =====
// watches both channels, predicts each filter verdict and compares it with the block's words
`timescale 1ns / 1ps

module rwdf_verdict_monitor #(
	parameter int WINDOW_BITS = 64,
	parameter int FLOW_SLOTS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	rwdf_in_if   rx,
	rwdf_out_if  res,
	output int   mismatches,
	output int   outstanding
);
	import rwdf_pkg::*;

	typedef struct packed {
		logic        deliver;
		logic [2:0]  drop_cause;
		logic [15:0] seq_out;
		logic [2:0]  kind_out;
		logic        spacing_updated;
		logic [31:0] spacing_value;
	} verdict_t;

	// per-flow window and spacing state
	logic [15:0]            flow_latest      [FLOW_SLOTS];
	logic [WINDOW_BITS-1:0] flow_seen        [FLOW_SLOTS];
	logic [31:0]            flow_first_tick  [FLOW_SLOTS];
	logic [31:0]            flow_second_tick [FLOW_SLOTS];
	logic [15:0]            flow_prev_seq    [FLOW_SLOTS];
	logic [31:0]            flow_spacing     [FLOW_SLOTS];

	verdict_t pending_verdicts[$];
	int       error_total;

	// classify one header and advance the flow state
	function automatic verdict_t classify_header(
		input logic [2:0]  kind,
		input logic [3:0]  flow,
		input logic        known,
		input logic [15:0] seq,
		input logic [31:0] tick
	);
		verdict_t    v;
		logic [15:0] lat;
		int unsigned gap;
		int          d;
		logic [31:0] divisor;
		logic        dup;
		v = '0;
		v.kind_out = kind;
		case (kind)
			KIND_INTEREST, KIND_ANNOUNCE: begin
				v.deliver = 1'b1;
			end
			KIND_INJECT: begin
				v.deliver = 1'b1;
				v.seq_out = seq;
			end
			KIND_DACK: begin
				v.drop_cause = CAUSE_DACK;
			end
			KIND_DATA: begin
				if (!known || flow >= FLOW_SLOTS) begin
					v.drop_cause = CAUSE_UNK_FLOW;
				end else begin
					lat = flow_latest[flow];
					dup = 1'b0;
					// ahead of the window: clear the skipped bits
					if (lat < seq) begin
						gap = seq - lat;
						if (gap >= WINDOW_BITS) begin
							flow_seen[flow] = '0;
						end else begin
							for (int k = 1; k <= gap; k++)
								flow_seen[flow][(lat + k) % WINDOW_BITS] = 1'b0;
						end
						lat = seq;
						flow_latest[flow] = seq;
					end else if (flow_seen[flow][seq % WINDOW_BITS]) begin
						dup = 1'b1;
					end
					if (dup) begin
						v.drop_cause = CAUSE_DUPLICATE;
					end else begin
						// only frames inside the window leave a mark
						if (int'(lat) - int'(seq) < WINDOW_BITS)
							flow_seen[flow][seq % WINDOW_BITS] = 1'b1;
						// one-time spacing estimate, a zero tick means not recorded
						if (flow_first_tick[flow] == 32'd0) begin
							flow_first_tick[flow] = tick;
						end else if (flow_second_tick[flow] == 32'd0) begin
							flow_second_tick[flow] = tick;
							d = int'(seq) - int'(flow_prev_seq[flow]);
							if (d > 0) begin
								divisor = d;
								flow_spacing[flow] = (tick - flow_first_tick[flow]) / divisor;
								v.spacing_updated = 1'b1;
							end
							flow_first_tick[flow] = 32'd0;
						end
						flow_prev_seq[flow] = seq;
						v.deliver = 1'b1;
						v.seq_out = seq;
					end
					v.spacing_value = flow_spacing[flow];
				end
			end
			default: begin
				v.drop_cause = CAUSE_UNK_KIND;
			end
		endcase
		return v;
	endfunction

	task automatic note_mismatch(input string what, input verdict_t want, input verdict_t got);
		error_total++;
		if (error_total <= 10)
			$display("%0t: %s: expected deliver=%0d cause=%0d seq=%h kind=%0d upd=%0d spacing=%h, got deliver=%0d cause=%0d seq=%h kind=%0d upd=%0d spacing=%h",
				$realtime, what, want.deliver, want.drop_cause, want.seq_out, want.kind_out,
				want.spacing_updated, want.spacing_value, got.deliver, got.drop_cause,
				got.seq_out, got.kind_out, got.spacing_updated, got.spacing_value);
	endtask

	// compare each taken result word, then predict the header word taken at this edge
	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			for (int f = 0; f < FLOW_SLOTS; f++) begin
				flow_latest[f]      = '0;
				flow_seen[f]        = '0;
				flow_first_tick[f]  = '0;
				flow_second_tick[f] = '0;
				flow_prev_seq[f]    = '0;
				flow_spacing[f]     = '0;
			end
			pending_verdicts.delete();
			error_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (res.valid && res.ready) begin
				got = {res.deliver, res.drop_cause, res.seq_out, res.kind_out,
					res.spacing_updated, res.spacing_value};
				if (pending_verdicts.size() == 0) begin
					note_mismatch("result word with nothing pending", '0, got);
				end else begin
					want = pending_verdicts.pop_front();
					if (got.deliver !== want.deliver || got.drop_cause !== want.drop_cause ||
						got.seq_out !== want.seq_out || got.kind_out !== want.kind_out ||
						got.spacing_updated !== want.spacing_updated ||
						got.spacing_value !== want.spacing_value)
						note_mismatch("verdict mismatch", want, got);
				end
			end
			if (rx.valid && rx.ready)
				pending_verdicts.push_back(classify_header(rx.frame_kind, rx.flow_index,
					rx.flow_known, rx.frame_seq, rx.arrival_tick));
			mismatches  <= error_total;
			outstanding <= pending_verdicts.size();
		end
	end

endmodule

// ===== tb/sv/rx_window_duplicate_filter_tb.sv =====
// top of the duplicate filter bench: clock, reset, header stimulus, result stalls and verdict
`timescale 1ns / 1ps

module rx_window_duplicate_filter_tb;
	import rwdf_pkg::*;

	localparam int WINDOW_BITS  = 64;
	localparam int FLOW_SLOTS   = 16;
	localparam int RANDOM_WORDS = 450;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 60;

	// kinds with no meaning to the filter
	localparam logic [2:0] KIND_RSVD_3 = 3'd3;
	localparam logic [2:0] KIND_RSVD_6 = 3'd6;
	localparam logic [2:0] KIND_RSVD_7 = 3'd7;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   cycle_count;
	int   send_calm;
	int   take_calm;

	logic [15:0] flow_cursor [FLOW_SLOTS];
	logic [31:0] tick_cursor [FLOW_SLOTS];

	rwdf_in_if  rx_ch();
	rwdf_out_if res_ch();

	rx_window_duplicate_filter #(
		.WINDOW_BITS(WINDOW_BITS),
		.FLOW_SLOTS (FLOW_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	rwdf_verdict_monitor #(
		.WINDOW_BITS(WINDOW_BITS),
		.FLOW_SLOTS (FLOW_SLOTS)
	) verdict_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.res        (res_ch),
		.mismatches (fail_count),
		.outstanding(outstanding)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// idle cycles before a word, with calm stretches of none
	function automatic int draw_gap(inout int calm);
		int gap;
		if (calm > 0) begin
			calm--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			gap = 0;
		end else
			gap = $urandom_range(0, 7);
		return gap;
	endfunction

	task automatic send_header(
		input logic [2:0]  kind,
		input logic [3:0]  flow,
		input logic        known,
		input logic [15:0] seq,
		input logic [31:0] tick
	);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid        <= 1'b1;
		rx_ch.frame_kind   <= kind;
		rx_ch.flow_index   <= flow;
		rx_ch.flow_known   <= known;
		rx_ch.frame_seq    <= seq;
		rx_ch.arrival_tick <= tick;
		do @(posedge clk); while (!rx_ch.ready);
	endtask

	task automatic send_data(input logic [3:0] flow, input logic [15:0] seq,
		input logic [31:0] tick);
		send_header(KIND_DATA, flow, 1'b1, seq, tick);
	endtask

	// result side stalls
	initial begin
		int stall;
		take_calm = 0;
		res_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_gap(take_calm);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// header stimulus and verdict
	initial begin
		int          pick;
		int          step;
		logic [3:0]  flow;
		logic [15:0] seq;
		logic [31:0] tick;
		logic [2:0]  kind;
		send_calm = 0;
		arst_n             <= 1'b0;
		rx_ch.valid        <= 1'b0;
		rx_ch.frame_kind   <= KIND_INTEREST;
		rx_ch.flow_index   <= '0;
		rx_ch.flow_known   <= 1'b0;
		rx_ch.frame_seq    <= '0;
		rx_ch.arrival_tick <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// non-data kinds, some at field extremes
		send_header(KIND_INTEREST, 4'd15, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(KIND_ANNOUNCE, 4'd0, 1'b0, 16'h0000, 32'd0);
		send_header(KIND_INJECT, 4'd7, 1'b0, 16'hFFFF, 32'd12345);
		send_header(KIND_INJECT, 4'd8, 1'b1, 16'h0000, 32'd0);
		send_header(KIND_DACK, 4'd3, 1'b1, 16'h1234, 32'd1);
		send_header(KIND_RSVD_3, 4'd1, 1'b1, 16'h00FF, 32'd2);
		send_header(KIND_RSVD_6, 4'd2, 1'b0, 16'hFF00, 32'd3);
		send_header(KIND_RSVD_7, 4'd5, 1'b1, 16'h5A5A, 32'd4);
		// data for a flow that is not in the table
		send_header(KIND_DATA, 4'd0, 1'b0, 16'd5, 32'd100);
		// first frame, duplicate, spacing from the second delivered frame
		send_data(4'd0, 16'd0, 32'd100);
		send_data(4'd0, 16'd0, 32'd150);
		send_data(4'd0, 16'd5, 32'd600);
		// jump past the whole window, then an old frame that is never marked
		send_data(4'd0, 16'd200, 32'd700);
		send_data(4'd0, 16'd100, 32'd800);
		send_data(4'd0, 16'd100, 32'd900);
		// older frame inside the window is marked and then a duplicate
		send_data(4'd0, 16'd150, 32'd1000);
		send_data(4'd0, 16'd150, 32'd1100);
		// negative sequence gap leaves the spacing alone
		send_data(4'd1, 16'd10, 32'd1000);
		send_data(4'd1, 16'd8, 32'd2000);
		// zero tick not recorded, tick counter wrapping in the spacing
		send_data(4'd2, 16'd3, 32'd0);
		send_data(4'd2, 16'd9, 32'hFFFF_FFF0);
		send_data(4'd2, 16'd12, 32'd40);
		// zero sequence gap leaves the spacing alone
		send_data(4'd4, 16'd1000, 32'd0);
		send_data(4'd4, 16'd500, 32'd7);
		send_data(4'd4, 16'd500, 32'd9);
		send_data(4'd15, 16'hFFFF, 32'hFFFF_FFFF);

		for (int f = 0; f < FLOW_SLOTS; f++) begin
			flow_cursor[f] = $urandom_range(0, 2000);
			tick_cursor[f] = $urandom;
		end

		// random part: mostly ordered data per flow with reorder, repeats and jumps
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) < 7)
				flow = $urandom_range(0, 3);
			else
				flow = $urandom_range(0, FLOW_SLOTS - 1);
			if (pick < 62) begin
				step = $urandom_range(0, 99);
				if (step < 50)
					seq = flow_cursor[flow] + $urandom_range(1, 3);
				else if (step < 70)
					seq = flow_cursor[flow] - $urandom_range(0, 12);
				else if (step < 78)
					seq = flow_cursor[flow] - $urandom_range(50, 300);
				else if (step < 90)
					seq = flow_cursor[flow] + $urandom_range(4, 400);
				else
					seq = $urandom;
				if (seq > flow_cursor[flow])
					flow_cursor[flow] = seq;
				tick_cursor[flow] = tick_cursor[flow] + $urandom_range(1, 5000);
				step = $urandom_range(0, 19);
				if (step == 0)
					tick = 32'd0;
				else if (step == 1)
					tick = $urandom;
				else
					tick = tick_cursor[flow];
				send_data(flow, seq, tick);
			end else if (pick < 70) begin
				send_header(KIND_DATA, flow, 1'b0, $urandom, $urandom);
			end else begin
				case ($urandom_range(0, 6))
					0: kind = KIND_INTEREST;
					1: kind = KIND_DACK;
					2: kind = KIND_ANNOUNCE;
					3: kind = KIND_INJECT;
					4: kind = KIND_RSVD_3;
					5: kind = KIND_RSVD_6;
					default: kind = KIND_RSVD_7;
				endcase
				send_header(kind, flow, $urandom_range(0, 1), $urandom, $urandom);
			end
		end
		rx_ch.valid <= 1'b0;

		// drain, then allow for the divider and a last stall
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
